>>> rtl/core/bmr_pkg.sv
// ----------------------------------------------------------------------------
// bmr_pkg: shared types and constants of the message reassembler
// Frame header constants, phase and error codes, config and result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bmr_pkg;

  localparam int unsigned MaxFrameDefault = 512;

  localparam logic [7:0] CmdKeepalive = 8'h82;
  localparam logic [7:0] CmdMessage   = 8'h83;

  localparam logic [9:0] InitHdr = 10'd3;
  localparam logic [9:0] ContHdr = 10'd1;

  localparam logic [9:0]  FragmentSizeReset   = 10'd64;
  localparam logic [15:0] BufferCapacityReset = 16'd2048;

  typedef enum logic [1:0] {
    PH_INIT = 2'b01,
    PH_CONT = 2'b10
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_CMD   = 3'd1,
    ERR_SHORT     = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_OVERRUN   = 3'd4,
    ERR_SEQUENCE  = 3'd5,
    ERR_FRAG_SIZE = 3'd6
  } err_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_ERROR   = 1'b1
  } kind_t;

  typedef enum logic {
    REG_FRAGMENT_SIZE   = 1'b0,
    REG_BUFFER_CAPACITY = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [9:0]  fragment_size;
    logic [15:0] buffer_capacity;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last;
    err_t        error_code;
    logic [15:0] message_length;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/bmr_parser.sv
// ----------------------------------------------------------------------------
// bmr_parser: frame parser and message state
// Holds the reassembly state and turns one received byte into at most one
// result per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmr_parser
  import bmr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MaxFrameDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_end,
  output logic            res_valid,
  output result_t         res
);

  localparam logic [9:0] MaxFrame = 10'(MAX_FRAME);

  phase_t      phase, phase_next;
  logic [9:0]  byte_in_frame, byte_in_frame_next;
  logic [9:0]  frame_limit, frame_limit_next;
  logic [15:0] announced_length, announced_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [6:0]  expected_seq, expected_seq_next;
  logic        skip_frame, skip_frame_next;

  logic [9:0]  f_eff;
  logic [9:0]  init_room, init_pay, init_limit;
  logic [9:0]  cont_room, cont_pay, cont_limit;
  logic        at_limit;
  logic [15:0] rem_dec;
  logic        do_fail;
  err_t        fail_code;

  // read limits for a frame starting now
  assign f_eff      = (cfg.fragment_size < MaxFrame) ? cfg.fragment_size : MaxFrame;
  assign init_room  = f_eff - InitHdr;
  assign init_pay   = ({6'b0, init_room} > cfg.buffer_capacity) ?
                      cfg.buffer_capacity[9:0] : init_room;
  assign init_limit = init_pay + InitHdr;
  assign cont_room  = (f_eff >= ContHdr) ? (f_eff - ContHdr) : (MaxFrame - ContHdr);
  assign cont_pay   = ({6'b0, cont_room} > bytes_remaining) ?
                      bytes_remaining[9:0] : cont_room;
  assign cont_limit = cont_pay + ContHdr;

  assign at_limit = ({1'b0, byte_in_frame} + 11'd1) >= {1'b0, frame_limit};
  assign rem_dec  = bytes_remaining - 16'd1;

  always_comb begin
    phase_next            = phase;
    byte_in_frame_next    = byte_in_frame;
    frame_limit_next      = frame_limit;
    announced_length_next = announced_length;
    bytes_remaining_next  = bytes_remaining;
    expected_seq_next     = expected_seq;
    skip_frame_next       = skip_frame;
    do_fail               = 1'b0;
    fail_code             = ERR_NONE;
    res_valid             = 1'b0;
    res.kind              = KIND_PAYLOAD;
    res.payload_byte      = rx_byte;
    res.last              = 1'b0;
    res.error_code        = ERR_NONE;
    res.message_length    = announced_length;

    if (step && !skip_frame) begin
      case (phase)
        PH_INIT: begin
          if (byte_in_frame == 10'd0) begin
            announced_length_next = '0;
            if (cfg.fragment_size <= InitHdr) begin
              do_fail   = 1'b1;
              fail_code = ERR_FRAG_SIZE;
            end else if (rx_byte == CmdKeepalive) begin
              skip_frame_next = !frame_end;
            end else if (rx_byte != CmdMessage) begin
              do_fail   = 1'b1;
              fail_code = ERR_BAD_CMD;
            end else if (frame_end) begin
              do_fail   = 1'b1;
              fail_code = ERR_SHORT;
            end else begin
              frame_limit_next = init_limit;
            end
          end else if (byte_in_frame == 10'd1) begin
            if (frame_end) begin
              do_fail   = 1'b1;
              fail_code = ERR_SHORT;
            end else begin
              bytes_remaining_next = {8'd0, rx_byte};
            end
          end else if (byte_in_frame == 10'd2) begin
            if (frame_end || frame_limit <= InitHdr) begin
              do_fail   = 1'b1;
              fail_code = ERR_SHORT;
            end else begin
              announced_length_next = {bytes_remaining[7:0], rx_byte};
              if ({bytes_remaining[7:0], rx_byte} > cfg.buffer_capacity) begin
                do_fail   = 1'b1;
                fail_code = ERR_TOO_LONG;
              end else begin
                bytes_remaining_next = {bytes_remaining[7:0], rx_byte};
                expected_seq_next    = '0;
              end
            end
          end else if (bytes_remaining == '0) begin
            do_fail   = 1'b1;
            fail_code = ERR_OVERRUN;
          end else begin
            bytes_remaining_next = rem_dec;
            res_valid            = 1'b1;
            if (rem_dec == '0) begin
              res.last = frame_end || at_limit;
              if (frame_end || at_limit) skip_frame_next = !frame_end;
            end else if (frame_end || at_limit) begin
              phase_next      = PH_CONT;
              skip_frame_next = !frame_end;
            end
          end
        end
        PH_CONT: begin
          if (byte_in_frame == 10'd0) begin
            frame_limit_next = cont_limit;
            if (frame_end || cont_limit <= ContHdr) begin
              do_fail   = 1'b1;
              fail_code = ERR_SHORT;
            end else if (rx_byte != {1'b0, expected_seq}) begin
              do_fail   = 1'b1;
              fail_code = ERR_SEQUENCE;
            end else begin
              expected_seq_next = expected_seq + 7'd1;
            end
          end else if (bytes_remaining == '0) begin
            do_fail   = 1'b1;
            fail_code = ERR_OVERRUN;
          end else begin
            bytes_remaining_next = rem_dec;
            res_valid            = 1'b1;
            if (rem_dec == '0) begin
              res.last        = 1'b1;
              phase_next      = PH_INIT;
              skip_frame_next = !frame_end;
            end else if (!frame_end && at_limit) begin
              skip_frame_next = 1'b1;
            end
          end
        end
        default: begin
          phase_next = PH_INIT;
        end
      endcase

      if (do_fail) begin
        res_valid        = 1'b1;
        res.kind         = KIND_ERROR;
        res.payload_byte = '0;
        res.last         = 1'b1;
        res.error_code   = fail_code;
        phase_next       = PH_INIT;
        skip_frame_next  = !frame_end;
      end
      res.message_length = announced_length_next;
    end

    if (step) begin
      if (frame_end) begin
        byte_in_frame_next = '0;
        skip_frame_next    = 1'b0;
      end else if (!skip_frame_next) begin
        byte_in_frame_next = byte_in_frame + 10'd1;
      end else begin
        byte_in_frame_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_INIT;
      byte_in_frame    <= '0;
      frame_limit      <= '0;
      announced_length <= '0;
      bytes_remaining  <= '0;
      expected_seq     <= '0;
      skip_frame       <= 1'b0;
    end else begin
      phase            <= phase_next;
      byte_in_frame    <= byte_in_frame_next;
      frame_limit      <= frame_limit_next;
      announced_length <= announced_length_next;
      bytes_remaining  <= bytes_remaining_next;
      expected_seq     <= expected_seq_next;
      skip_frame       <= skip_frame_next;
    end
  end

`ifndef SYNTHESIS
  a_frame_end_restarts: assert property (@(posedge clk) disable iff (rst)
    step && frame_end |=> byte_in_frame == '0 && !skip_frame)
    else $error("byte count not cleared after frame end");

  a_skip_at_zero: assert property (@(posedge clk) disable iff (rst)
    skip_frame |-> byte_in_frame == '0)
    else $error("byte count advanced while dropping a frame");

  a_cont_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CONT |-> bytes_remaining != '0)
    else $error("continuation phase with nothing left of the message");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ble_message_reassembler_unit.sv
// ----------------------------------------------------------------------------
// ble_message_reassembler_unit: fragmented link message reassembler
// Rebuilds one message from received link frame bytes and streams its payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per item (rx_byte) with frame_end set on
//   the last byte of each link frame. Output channel: at most one item per
//   input byte, either a payload byte (last set on the final byte of the
//   message) or an error report carrying error_code; message_length gives the
//   length announced by the current init frame header.
//   Config: cfg_we writes cfg_data into register cfg_index (0 fragment_size,
//   1 buffer_capacity); write only while no item is in flight.
//   Throughput: one byte per cycle while in_stall is low; each byte only updates
//   counters and compares them against the registered frame state.
//   Path: a byte is captured in the input register, parsed from there, and its
//   result is registered into the output buffer, or into the skid register.
//   Reset: parser state returns to waiting for an init frame, registers go to
//   64 and 2048, and both the input register and output buffer are emptied.
//   Stall: the output holds steady while stalled; a second result lands in a
//   skid register, and in_stall rises only while that skid register is full
//   and a byte is waiting in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_message_reassembler_unit
  import bmr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MaxFrameDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       payload_byte,
  output logic             last,
  output logic [2:0]       error_code,
  output logic [15:0]      message_length
);

  cfg_t       cfg;
  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_end;
  logic       process;
  logic       res_valid;
  result_t    res;
  result_t    head, skid;
  logic       head_valid, skid_valid;
  logic       out_fire, push;

  assign in_stall = item_valid && skid_valid;
  assign process  = item_valid && !skid_valid;
  assign out_fire = head_valid && !out_stall;
  assign push     = process && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fragment_size   <= FragmentSizeReset;
      cfg.buffer_capacity <= BufferCapacityReset;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_FRAGMENT_SIZE:   cfg.fragment_size   <= cfg_data[9:0];
        REG_BUFFER_CAPACITY: cfg.buffer_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  bmr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (process),
    .rx_byte   (item_byte),
    .frame_end (item_end),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!in_stall) item_valid <= in_valid;
      if (skid_valid) begin
        if (out_fire) skid_valid <= 1'b0;
      end else if (!head_valid || out_fire) begin
        head_valid <= push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_byte <= rx_byte;
      item_end  <= frame_end;
    end
    if (skid_valid) begin
      if (out_fire) head <= skid;
    end else if (!head_valid || out_fire) begin
      if (push) head <= res;
    end else if (push) begin
      skid <= res;
    end
  end

  assign out_valid      = head_valid;
  assign kind           = head.kind;
  assign payload_byte   = head.payload_byte;
  assign last           = head.last;
  assign error_code     = head.error_code;
  assign message_length = head.message_length;

`ifndef SYNTHESIS
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid register holds an item while the output is empty");

  a_error_report_form: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.kind == KIND_ERROR |->
      head.last && head.error_code != ERR_NONE && head.payload_byte == '0)
    else $error("malformed error report");

  a_push_to_skid: assert property (@(posedge clk) disable iff (rst)
    push && head_valid && !out_fire |=> skid_valid)
    else $error("result lost while the output was stalled");
`endif

endmodule

`default_nettype wire
